// ===== src/ckbd_pkg.sv =====
// Shared types and constants for the capacitive key baseline detector.
// No dependencies; imported by the key cell and the top level.
`timescale 1ns / 1ps
package ckbd_pkg;

	localparam int NUM_KEYS   = 4;
	localparam int CAL_PASSES = 15;
	localparam int CNT_W      = 16;
	localparam int THR_W      = 15;
	localparam int STEP_W     = $clog2(CAL_PASSES + 2);
	localparam int LED_W      = 5;
	localparam int OUT_W      = 16;

	localparam logic [THR_W-1:0]  THRESH_RESET = THR_W'(30);
	localparam logic [STEP_W-1:0] STEP_RUN     = STEP_W'(CAL_PASSES + 1);

	// LED bit positions
	localparam int LED_KEY0 = 3;
	localparam int LED_KEY1 = 4;
	localparam int LED_KEY2 = 1;
	localparam int LED_KEY3 = 0;

	typedef enum logic [1:0] {
		MODE_LOAD,
		MODE_AVG,
		MODE_RUN
	} cell_mode_t;

	// One scan as it moves down the chain. Counts shift toward index 0 so
	// each cell consumes cnt[0]; pressed flags shift in at the top.
	typedef struct packed {
		cell_mode_t                     mode;
		logic [THR_W-1:0]               run;
		logic [NUM_KEYS-1:0][CNT_W-1:0] cnt;
		logic [NUM_KEYS-1:0]            pressed;
	} scan_t;

endpackage

// ===== src/ckbd_cell.sv =====
// One key cell: holds that key's baseline and one stage of the scan chain.
// Depends on ckbd_pkg.
`timescale 1ns / 1ps
module ckbd_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ckbd_pkg::scan_t in_word,
	output logic          out_valid,
	input  logic          out_ready,
	output ckbd_pkg::scan_t out_word
);
	import ckbd_pkg::*;

	logic             valid_q;
	scan_t            word_q;
	logic [CNT_W-1:0] baseline_q;

	logic [CNT_W-1:0] cnt;
	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] avg;
	logic [CNT_W-1:0] diff;
	logic             neg;
	logic             press;
	logic [CNT_W-1:0] base_nxt;
	logic [CNT_W-1:0] base_hold;
	scan_t            word_nxt;
	logic             load;

	assign in_ready = ~valid_q | out_ready;
	assign load     = in_valid & in_ready;

	always_comb begin
		cnt   = in_word.cnt[0];
		sum   = {1'b0, baseline_q} + {1'b0, cnt};
		avg   = sum[CNT_W:1];
		diff  = baseline_q - cnt;
		neg   = diff[CNT_W-1];
		press = 1'b0;
		base_hold = neg ? avg : baseline_q;
		unique case (in_word.mode)
			MODE_LOAD: base_nxt = cnt;
			MODE_AVG:  base_nxt = avg;
			MODE_RUN: begin
				// negative delta reads as zero, never beats the running max
				press    = ~neg && (diff[THR_W-1:0] > in_word.run);
				base_nxt = press ? baseline_q : base_hold - CNT_W'(1);
			end
			default:   base_nxt = baseline_q;
		endcase

		word_nxt         = in_word;
		word_nxt.run     = press ? diff[THR_W-1:0] : in_word.run;
		word_nxt.cnt     = {CNT_W'(0), in_word.cnt[NUM_KEYS-1:1]};
		word_nxt.pressed = {press, in_word.pressed[NUM_KEYS-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			baseline_q <= '0;
		end else begin
			if (in_ready)
				valid_q <= in_valid;
			if (load)
				baseline_q <= base_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			word_q <= word_nxt;
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

// ===== src/capacitive_key_baseline_detector.sv =====
// Top level of the capacitive key baseline detector: stream ports, threshold
// register, calibration counter and the chain of key cells. Depends on
// ckbd_pkg and ckbd_cell.
`timescale 1ns / 1ps
// Takes one scan word (four oscillator counts) and returns one result word
// with per-key pressed flags, the LED pattern and a calibrating flag in
// tuser. The first scan after reset loads the baselines and the next fifteen
// average into them; results of those sixteen scans carry calibrating = 1
// and all-zero flags. After that each key's baseline-minus-count is compared,
// key 0 first, against a running maximum seeded by press_threshold. The
// keys sit in a row of four cells, one pipeline stage each, each owning its
// key's baseline and handing the running maximum to the next: a new scan is
// accepted every cycle unless a master-side stall backs up to the first
// cell, and its result word passes through the four cell registers in turn,
// the last cell's register acting as the output register. Stalls on the
// master side back up stage by stage, so empty stages still take new scans.
// press_threshold resets to 30 and should only be written while the block is
// idle.
module capacitive_key_baseline_detector (
	input  logic        clk,
	input  logic        arst_n,
	// threshold register
	input  logic        cfg_we,
	input  logic [14:0] cfg_wdata,   // press_threshold
	// scan in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,     // count_key0[15:0], count_key1, count_key2, count_key3
	// result out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,     // pressed_key0..3 [3:0], led_pattern [8:4], zero [15:9]
	output logic        m_tuser      // calibrating
);
	import ckbd_pkg::*;

	logic [THR_W-1:0]  threshold_q;
	logic [STEP_W-1:0] cal_step_q;

	logic [NUM_KEYS:0] ch_valid;
	logic [NUM_KEYS:0] ch_ready;
	scan_t             ch_word [NUM_KEYS+1];

	logic              accept;
	cell_mode_t        entry_mode;
	scan_t             last_word;
	logic [LED_W-1:0]  led;

	assign accept = s_tvalid & s_tready;

	// threshold register, plain write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			threshold_q <= THRESH_RESET;
		else if (cfg_we)
			threshold_q <= cfg_wdata;
	end

	// calibration counter: sticks at STEP_RUN
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cal_step_q <= '0;
		else if (accept && cal_step_q != STEP_RUN)
			cal_step_q <= cal_step_q + STEP_W'(1);
	end

	always_comb begin
		if (cal_step_q == '0)
			entry_mode = MODE_LOAD;
		else if (cal_step_q != STEP_RUN)
			entry_mode = MODE_AVG;
		else
			entry_mode = MODE_RUN;
	end

	// head of chain: the mode travels with the scan
	always_comb begin
		ch_word[0].mode    = entry_mode;
		ch_word[0].run     = threshold_q;
		ch_word[0].pressed = '0;
		for (int k = 0; k < NUM_KEYS; k++)
			ch_word[0].cnt[k] = s_tdata[k*CNT_W +: CNT_W];
	end

	assign ch_valid[0] = s_tvalid;
	assign s_tready    = ch_ready[0];

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_cell
		ckbd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (ch_valid[k]),
			.in_ready  (ch_ready[k]),
			.in_word   (ch_word[k]),
			.out_valid (ch_valid[k+1]),
			.out_ready (ch_ready[k+1]),
			.out_word  (ch_word[k+1])
		);
	end

	assign ch_ready[NUM_KEYS] = m_tready;
	assign last_word          = ch_word[NUM_KEYS];

	always_comb begin
		led           = '0;
		led[LED_KEY0] = last_word.pressed[0];
		led[LED_KEY1] = last_word.pressed[1];
		led[LED_KEY2] = last_word.pressed[2];
		led[LED_KEY3] = last_word.pressed[3];
	end

	assign m_tvalid = ch_valid[NUM_KEYS];
	assign m_tdata  = {(OUT_W - NUM_KEYS - LED_W)'(0), led, last_word.pressed};
	assign m_tuser  = (last_word.mode != MODE_RUN);

endmodule

// ===== src/ckbd_checker.sv =====
// Port-level checks for the capacitive key baseline detector, with the bind
// that attaches them to the top level. Depends on the top level's ports only.
`timescale 1ns / 1ps
module ckbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	// calibration results carry no flags and no LEDs
	a_cal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 16'h0000)
		else $error("calibrating word with nonzero flags");

	// LED pattern mirrors the pressed flags
	a_led_map: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7] == m_tdata[0] && m_tdata[8] == m_tdata[1] &&
			m_tdata[5] == m_tdata[2] && m_tdata[4] == m_tdata[3] && m_tdata[6] == 1'b0)
		else $error("led pattern does not match pressed flags");

	// padding stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:9] == 7'h00)
		else $error("padding bits set");

	// once out of calibration, never back in without reset
	a_cal_once: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser ##1 m_tvalid |-> !m_tuser)
		else $error("calibrating after normal operation");

endmodule

bind capacitive_key_baseline_detector ckbd_checker u_ckbd_checker (.*);
